[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL of the ADC averaging block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[src/adcavg_pkg.sv]
// ---------------------------------------------------------------------------
// adcavg_pkg
// Types and fixed constants of the ADC block average and scaling block.
// ---------------------------------------------------------------------------
package adcavg_pkg;

   localparam int unsigned NUM_CH     = 4;
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned GAIN_W     = 22;
   localparam int unsigned OFFSET_W   = 13;
   localparam int unsigned RESULT_W   = 16;
   localparam int unsigned Q_FRAC     = 16;
   localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W;   // avg * gain
   localparam int unsigned SCALED_W   = PROD_W - Q_FRAC;     // after Q16 drop
   localparam int unsigned CPROD_W    = SCALED_W + GAIN_W;   // pin delta * gain
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned IN_DATA_W  = NUM_CH * SAMPLE_W;
   localparam int unsigned OUT_DATA_W = NUM_CH * SAMPLE_W + NUM_CH * RESULT_W;

   // Channel positions (lane numbers and tdata order)
   localparam int unsigned CH_12V = 0;
   localparam int unsigned CH_5V  = 1;
   localparam int unsigned CH_3V3 = 2;
   localparam int unsigned CH_CUR = 3;

   // Reset values of the configuration registers
   localparam logic [GAIN_W-1:0]   RST_GAIN_12V    = GAIN_W'(633600);
   localparam logic [GAIN_W-1:0]   RST_GAIN_5V     = GAIN_W'(252930);
   localparam logic [GAIN_W-1:0]   RST_GAIN_3V3    = GAIN_W'(168960);
   localparam logic [GAIN_W-1:0]   RST_GAIN_PIN    = GAIN_W'(52800);
   localparam logic [OFFSET_W-1:0] RST_OFFSET_MV   = OFFSET_W'(2500);
   localparam logic [GAIN_W-1:0]   RST_SENSOR_GAIN = GAIN_W'(294912);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAIN_12V,
      CSR_GAIN_5V,
      CSR_GAIN_3V3,
      CSR_GAIN_PIN,
      CSR_OFFSET_MV,
      CSR_SENSOR_GAIN
   } csr_index_type;

   typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_vec_type;
   typedef logic [NUM_CH-1:0][SCALED_W-1:0] scaled_vec_type;

   // Sequencer to lanes
   typedef struct packed {
      logic             accept;    // scan request taken this cycle
      logic             last;      // this scan closes the block
      logic             div_step;  // divide the block sum this cycle
      logic             mul_step;  // gain multiply this cycle
   } lane_ctrl_type;

   // Sequencer to merge stage
   typedef struct packed {
      logic sub_step;   // pin minus offset
      logic cmul_step;  // delta times sensor gain
      logic load;       // capture result into output register
   } merge_ctrl_type;

   // Clamp an unsigned Q16-dropped product to 16 bits
   function automatic logic [RESULT_W-1:0] sat_scaled(input logic [SCALED_W-1:0] v);
      logic [RESULT_W-1:0] r;
      r = (|v[SCALED_W-1:RESULT_W]) ? {RESULT_W{1'b1}} : v[RESULT_W-1:0];
      return r;
   endfunction

endpackage

[src/adcavg_lane.sv]
// ---------------------------------------------------------------------------
// adcavg_lane
// One channel: running sum, reciprocal divide by the scan count, Q16 gain multiply.
// ---------------------------------------------------------------------------
module adcavg_lane #(
   parameter int unsigned SCAN_COUNT = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  adcavg_pkg::lane_ctrl_type        ctrl,
   input  logic [adcavg_pkg::SAMPLE_W-1:0]  sample,
   input  logic [adcavg_pkg::GAIN_W-1:0]    gain,
   output logic [adcavg_pkg::SAMPLE_W-1:0]  avg,
   output logic [adcavg_pkg::SCALED_W-1:0]  scaled
);
   import adcavg_pkg::*;

   localparam int unsigned DIV_SH  = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 0;
   localparam int unsigned SUM_W   = SAMPLE_W + DIV_SH;
   // Reciprocal ceil(2^RCP_SH / SCAN_COUNT) is exact for every SUM_W-bit sum
   localparam int unsigned RCP_SH  = SUM_W + DIV_SH;
   localparam int unsigned RCP_W   = SUM_W + 1;
   localparam int unsigned QPROD_W = SUM_W + RCP_W;
   localparam longint unsigned RCP_FULL =
      ((64'd1 << RCP_SH) + 64'(SCAN_COUNT) - 64'd1) / 64'(SCAN_COUNT);
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_FULL);

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    blk_sum_ff, blk_sum_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SUM_W-1:0]    sum_total;
   logic [QPROD_W-1:0]  quo_prod;

   assign sum_total = sum_ff + SUM_W'(sample);
   assign quo_prod  = QPROD_W'(blk_sum_ff) * QPROD_W'(RECIP);

   // Accumulate; the closing scan clears the sum
   always_comb begin
      sum_in = sum_ff;
      if (ctrl.accept) begin
         sum_in = ctrl.last ? '0 : sum_total;
      end
   end

   // Hold the block sum, then divide by multiplying with the reciprocal
   always_comb begin
      blk_sum_in = blk_sum_ff;
      quo_in     = quo_ff;
      if (ctrl.accept && ctrl.last) begin
         blk_sum_in = sum_total;
      end
      if (ctrl.div_step) begin
         quo_in = quo_prod[RCP_SH +: SAMPLE_W];
      end
   end

   // Q16 gain product
   assign prod_in = ctrl.mul_step ? (PROD_W'(quo_ff) * PROD_W'(gain)) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_sum_ff <= blk_sum_in;
      quo_ff     <= quo_in;
      prod_ff    <= prod_in;
   end

   assign avg    = quo_ff;
   assign scaled = prod_ff[PROD_W-1:Q_FRAC];

endmodule

[src/adcavg_merge.sv]
// ---------------------------------------------------------------------------
// adcavg_merge
// Combines lane results: rail saturation, current offset and gain, output register.
// ---------------------------------------------------------------------------
module adcavg_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  adcavg_pkg::merge_ctrl_type         ctrl,
   input  adcavg_pkg::sample_vec_type         avg,
   input  adcavg_pkg::scaled_vec_type         scaled,
   input  logic [adcavg_pkg::OFFSET_W-1:0]    sensor_offset_mv,
   input  logic [adcavg_pkg::GAIN_W-1:0]      sensor_gain_ma,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [adcavg_pkg::OUT_DATA_W-1:0]  rsp_tdata
);
   import adcavg_pkg::*;

   logic [SCALED_W-1:0]   diff_ff, diff_in;
   logic [CPROD_W-1:0]    cprod_ff, cprod_in;
   logic [OUT_DATA_W-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;
   logic [SCALED_W-1:0]   pin_mv;
   logic [SCALED_W-1:0]   offset_ext;
   logic [CPROD_W-Q_FRAC-1:0] cur_hi;
   logic [RESULT_W-1:0]   cur_ma;

   assign pin_mv     = scaled[CH_CUR];
   assign offset_ext = SCALED_W'(sensor_offset_mv);

   // Pin deviation above the zero-current offset, clamped at zero
   always_comb begin
      diff_in = diff_ff;
      if (ctrl.sub_step) begin
         diff_in = (pin_mv > offset_ext) ? (pin_mv - offset_ext) : '0;
      end
   end

   assign cprod_in = ctrl.cmul_step ? (CPROD_W'(diff_ff) * CPROD_W'(sensor_gain_ma))
                                    : cprod_ff;

   assign cur_hi = cprod_ff[CPROD_W-1:Q_FRAC];
   assign cur_ma = (|cur_hi[CPROD_W-Q_FRAC-1:RESULT_W]) ? {RESULT_W{1'b1}}
                                                          : cur_hi[RESULT_W-1:0];

   // Output register; first field in the low bits
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff && !rsp_tready;
      if (ctrl.load) begin
         data_in  = {cur_ma,
                     sat_scaled(scaled[CH_3V3]),
                     sat_scaled(scaled[CH_5V]),
                     sat_scaled(scaled[CH_12V]),
                     avg[CH_CUR], avg[CH_3V3], avg[CH_5V], avg[CH_12V]};
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      cprod_ff <= cprod_in;
      data_ff  <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[src/adc_block_average_scale.sv]
// ---------------------------------------------------------------------------
// adc_block_average_scale
// Block average of a 4-channel ADC scan stream with Q16 scaling to mV and mA.
// ---------------------------------------------------------------------------
// Each request is one scan of four 12-bit samples. Scans are taken one per
// cycle while in ST_ACCUM and summed per channel; the SCAN_COUNT-th scan
// closes the block. The block is then finished with req_tready low, through
// ST_DIVIDE (the divide by SCAN_COUNT, a reciprocal multiply, in the four
// channel lanes), ST_MULT (the lane gain multiply) and three merge-stage
// states: ST_SUB (offset subtract), ST_CMUL (sensor gain multiply) and
// ST_LOAD (load of the output register), which waits while the previous
// result still sits unclaimed in the output register. While a result waits
// on rsp_tready the next block's scans are still taken.
// Register writes take effect at the next result.
`include "assert_macros.svh"

module adc_block_average_scale #(
   parameter int unsigned SCAN_COUNT = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Scan requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_rail_12v, sample_rail_5v, sample_rail_3v3, sample_current
   input  logic [adcavg_pkg::IN_DATA_W-1:0]     req_tdata,
   // Results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // avg_rail_12v, avg_rail_5v, avg_rail_3v3, avg_current,
   // rail_12v_mv, rail_5v_mv, rail_3v3_mv, load_current_ma
   output logic [adcavg_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   // Register writes
   input  logic                                 csr_we,
   input  logic [adcavg_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [adcavg_pkg::GAIN_W-1:0]        csr_wdata
);
   import adcavg_pkg::*;

   localparam int unsigned CNT_W = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;
   localparam logic [CNT_W-1:0] LAST_SCAN = CNT_W'(SCAN_COUNT - 1);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_MULT,
      ST_SUB,
      ST_CMUL,
      ST_LOAD
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;

   logic [GAIN_W-1:0]   gain_12v_ff, gain_5v_ff, gain_3v3_ff, gain_pin_ff, sensor_gain_ff;
   logic [OFFSET_W-1:0] offset_ff;

   logic           req_accept;
   logic           last_scan;
   logic           out_free;
   lane_ctrl_type  lane_ctrl;
   merge_ctrl_type merge_ctrl;
   sample_vec_type avg_vec;
   scaled_vec_type scaled_vec;
   logic [NUM_CH-1:0][GAIN_W-1:0] lane_gain;

   assign req_tready = (state_ff == ST_ACCUM);
   assign req_accept = req_tvalid && req_tready;
   assign last_scan  = (scan_cnt_ff == LAST_SCAN);
   assign out_free   = !rsp_tvalid || rsp_tready;

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      lane_ctrl   = '0;
      merge_ctrl  = '0;
      lane_ctrl.accept  = req_accept;
      lane_ctrl.last    = last_scan;
      case (state_ff)
         ST_ACCUM: begin
            if (req_accept) begin
               if (last_scan) begin
                  scan_cnt_in = '0;
                  state_in    = ST_DIVIDE;
               end else begin
                  scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_DIVIDE: begin
            lane_ctrl.div_step = 1'b1;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            lane_ctrl.mul_step = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            merge_ctrl.sub_step = 1'b1;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            merge_ctrl.cmul_step = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               merge_ctrl.load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_ACCUM;
         scan_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_12v_ff    <= RST_GAIN_12V;
         gain_5v_ff     <= RST_GAIN_5V;
         gain_3v3_ff    <= RST_GAIN_3V3;
         gain_pin_ff    <= RST_GAIN_PIN;
         offset_ff      <= RST_OFFSET_MV;
         sensor_gain_ff <= RST_SENSOR_GAIN;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GAIN_12V:    gain_12v_ff    <= csr_wdata;
            CSR_GAIN_5V:     gain_5v_ff     <= csr_wdata;
            CSR_GAIN_3V3:    gain_3v3_ff    <= csr_wdata;
            CSR_GAIN_PIN:    gain_pin_ff    <= csr_wdata;
            CSR_OFFSET_MV:   offset_ff      <= csr_wdata[OFFSET_W-1:0];
            CSR_SENSOR_GAIN: sensor_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign lane_gain[CH_12V] = gain_12v_ff;
   assign lane_gain[CH_5V]  = gain_5v_ff;
   assign lane_gain[CH_3V3] = gain_3v3_ff;
   assign lane_gain[CH_CUR] = gain_pin_ff;

   // Channel lanes
   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      adcavg_lane #(
         .SCAN_COUNT (SCAN_COUNT)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .sample (req_tdata[ch*SAMPLE_W +: SAMPLE_W]),
         .gain   (lane_gain[ch]),
         .avg    (avg_vec[ch]),
         .scaled (scaled_vec[ch])
      );
   end

   adcavg_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (merge_ctrl),
      .avg              (avg_vec),
      .scaled           (scaled_vec),
      .sensor_offset_mv (offset_ff),
      .sensor_gain_ma   (sensor_gain_ff),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tdata        (rsp_tdata)
   );

   // Checks
   `ASSERT_PROP(a_last_starts_divide, clock, reset, (req_accept && last_scan) |=> (state_ff == ST_DIVIDE), "closing scan did not start the divide")
   `ASSERT_PROP(a_divide_one_cycle, clock, reset, (state_ff == ST_DIVIDE) |=> (state_ff == ST_MULT), "divide did not finish in one cycle")
   `ASSERT_NEVER(a_load_overwrites, clock, reset, merge_ctrl.load && rsp_tvalid && !rsp_tready, "result loaded over an unclaimed one")
   `ASSERT_PROP(a_load_shows_result, clock, reset, merge_ctrl.load |=> rsp_tvalid, "loaded result not presented")
   `ASSERT_NEVER(a_scan_cnt_range, clock, reset, scan_cnt_ff > LAST_SCAN, "scan counter past block length")

endmodule

[tb/adc_block_average_scale_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adc_block_average_scale_tb
// Self-checking bench for the ADC block average and scaling block.
// ---------------------------------------------------------------------------
// Scan requests go in on the req_ stream and block results come back on the
// rsp_ stream. A scoreboard class keeps its own channel sums and register
// copies and predicts one result per SCAN_COUNT accepted scans. Register
// settings change between phases once the block has drained, including the
// saturating, all-zero and out-of-range corners. Both stream sides idle at
// random, except in the opening directed block and the closing phase.
// ---------------------------------------------------------------------------
module adc_block_average_scale_tb;
   import adcavg_pkg::*;

   localparam int unsigned SCANS_PER_BLOCK = 16;
   localparam int unsigned NUM_PHASES      = 10;
   localparam int unsigned SETTLE_CYCLES   = SCANS_PER_BLOCK + 24;
   localparam int unsigned CSR_SLOTS       = 8;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

   // One scan request, first field in the low bits
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_current;
      logic [SAMPLE_W-1:0] sample_rail_3v3;
      logic [SAMPLE_W-1:0] sample_rail_5v;
      logic [SAMPLE_W-1:0] sample_rail_12v;
   } scan_type;

   // One block result, first field in the low bits
   typedef struct packed {
      logic [RESULT_W-1:0] load_current_ma;
      logic [RESULT_W-1:0] rail_3v3_mv;
      logic [RESULT_W-1:0] rail_5v_mv;
      logic [RESULT_W-1:0] rail_12v_mv;
      logic [SAMPLE_W-1:0] avg_current;
      logic [SAMPLE_W-1:0] avg_rail_3v3;
      logic [SAMPLE_W-1:0] avg_rail_5v;
      logic [SAMPLE_W-1:0] avg_rail_12v;
   } block_result_type;

   // Block average predictor and store of pending block results
   class block_average_tracker;
      logic [GAIN_W-1:0]   gain_12v    = RST_GAIN_12V;
      logic [GAIN_W-1:0]   gain_5v     = RST_GAIN_5V;
      logic [GAIN_W-1:0]   gain_3v3    = RST_GAIN_3V3;
      logic [GAIN_W-1:0]   gain_pin    = RST_GAIN_PIN;
      logic [OFFSET_W-1:0] offset_mv   = RST_OFFSET_MV;
      logic [GAIN_W-1:0]   sensor_gain = RST_SENSOR_GAIN;
      int unsigned         sums [NUM_CH];
      int unsigned         scans;
      block_result_type    expected_blocks [$];
      int unsigned         errors;

      function new();
         foreach (sums[c]) sums[c] = 0;
         scans  = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] index, logic [GAIN_W-1:0] value);
         case (index)
            CSR_GAIN_12V:    gain_12v    = value;
            CSR_GAIN_5V:     gain_5v     = value;
            CSR_GAIN_3V3:    gain_3v3    = value;
            CSR_GAIN_PIN:    gain_pin    = value;
            CSR_OFFSET_MV:   offset_mv   = value[OFFSET_W-1:0];
            CSR_SENSOR_GAIN: sensor_gain = value;
            default: ;
         endcase
      endfunction

      function logic [63:0] q16(logic [63:0] a, logic [63:0] g);
         return (a * g) >> Q_FRAC;
      endfunction

      function logic [RESULT_W-1:0] clip16(logic [63:0] v);
         return (v > 64'hFFFF) ? {RESULT_W{1'b1}} : v[RESULT_W-1:0];
      endfunction

      function int unsigned pending();
         return expected_blocks.size();
      endfunction

      // Accumulate one scan; the closing scan of a block yields a result
      function void add_scan(scan_type s);
         logic [SAMPLE_W-1:0] avg [NUM_CH];
         logic [63:0]         pin;
         block_result_type    r;
         sums[CH_12V] += s.sample_rail_12v;
         sums[CH_5V]  += s.sample_rail_5v;
         sums[CH_3V3] += s.sample_rail_3v3;
         sums[CH_CUR] += s.sample_current;
         scans++;
         if (scans < SCANS_PER_BLOCK) return;
         foreach (avg[c]) begin
            avg[c]  = SAMPLE_W'(sums[c] / SCANS_PER_BLOCK);
            sums[c] = 0;
         end
         scans = 0;
         r.avg_rail_12v = avg[CH_12V];
         r.avg_rail_5v  = avg[CH_5V];
         r.avg_rail_3v3 = avg[CH_3V3];
         r.avg_current  = avg[CH_CUR];
         r.rail_12v_mv  = clip16(q16(avg[CH_12V], gain_12v));
         r.rail_5v_mv   = clip16(q16(avg[CH_5V], gain_5v));
         r.rail_3v3_mv  = clip16(q16(avg[CH_3V3], gain_3v3));
         // Pin voltage at or below the zero-current offset clamps to 0 mA
         pin = q16(avg[CH_CUR], gain_pin);
         if (pin <= 64'(offset_mv))
            r.load_current_ma = '0;
         else
            r.load_current_ma = clip16(q16(pin - 64'(offset_mv), sensor_gain));
         expected_blocks.push_back(r);
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_block(block_result_type got);
         block_result_type want;
         if (expected_blocks.size() == 0) begin
            $error("unexpected block result %h", got);
            errors++;
            return;
         end
         want = expected_blocks.pop_front();
         compare("avg_rail_12v", want.avg_rail_12v, got.avg_rail_12v);
         compare("avg_rail_5v", want.avg_rail_5v, got.avg_rail_5v);
         compare("avg_rail_3v3", want.avg_rail_3v3, got.avg_rail_3v3);
         compare("avg_current", want.avg_current, got.avg_current);
         compare("rail_12v_mv", want.rail_12v_mv, got.rail_12v_mv);
         compare("rail_5v_mv", want.rail_5v_mv, got.rail_5v_mv);
         compare("rail_3v3_mv", want.rail_3v3_mv, got.rail_3v3_mv);
         compare("load_current_ma", want.load_current_ma, got.load_current_ma);
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [GAIN_W-1:0]     csr_wdata  = '0;

   block_average_tracker tracker = new();

   logic [GAIN_W-1:0] next_settings [CSR_SLOTS];
   int unsigned       send_gap_pct   = 0;
   int unsigned       sink_stall_pct = 0;
   int unsigned       scans_sent     = 0;

   adc_block_average_scale #(
      .SCAN_COUNT(SCANS_PER_BLOCK)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watch both handshakes
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) tracker.add_scan(scan_type'(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_block(block_result_type'(rsp_tdata));
   end

   // Result sink with random stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && $urandom_range(0, 99) < sink_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Present one scan request and hold it until taken
   task automatic send_scan(input scan_type s);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      scans_sent++;
   endtask

   // Write the selected slots of next_settings, back to back
   task automatic load_settings(input logic [CSR_SLOTS-1:0] sel);
      for (int i = 0; i < CSR_SLOTS; i++) begin
         if (sel[i]) begin
            csr_we    <= 1'b1;
            csr_addr  <= CSR_ADDR_W'(i);
            csr_wdata <= next_settings[i];
            @(posedge clock);
            tracker.set_reg(CSR_ADDR_W'(i), next_settings[i]);
         end
      end
      csr_we <= 1'b0;
   endtask

   // Stop sending, wait for every pending result, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain(logic [GAIN_W-1:0] nominal);
      if ($urandom_range(0, 3) == 0) return GAIN_W'($urandom_range(0, GAIN_MAX));
      return GAIN_W'($urandom_range(0, 2 * nominal));
   endfunction

   initial begin
      scan_type         s;
      int unsigned      count;
      int unsigned      mode;
      int               v;
      logic [SAMPLE_W-1:0] level [NUM_CH];
      logic [CSR_SLOTS-1:0] sel;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed block at reset settings: full-scale then zero scans
      for (int k = 0; k < SCANS_PER_BLOCK; k++) begin
         s = (k < SCANS_PER_BLOCK / 2) ? '1 : '0;
         send_scan(s);
      end
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // Choose the register setting of this phase
         case (p)
            0: begin
               // saturation: every gain at maximum, no offset
               foreach (next_settings[i]) next_settings[i] = GAIN_MAX;
               next_settings[CSR_OFFSET_MV] = '0;
            end
            1: foreach (next_settings[i]) next_settings[i] = '0;
            2: begin
               // offset above its nominal range, masked to 13 bits
               foreach (next_settings[i]) next_settings[i] = GAIN_MAX;
            end
            3: begin
               next_settings[CSR_GAIN_12V]    = RST_GAIN_12V;
               next_settings[CSR_GAIN_5V]     = RST_GAIN_5V;
               next_settings[CSR_GAIN_3V3]    = RST_GAIN_3V3;
               next_settings[CSR_GAIN_PIN]    = RST_GAIN_PIN;
               next_settings[CSR_OFFSET_MV]   = GAIN_W'(RST_OFFSET_MV);
               next_settings[CSR_SENSOR_GAIN] = RST_SENSOR_GAIN;
               next_settings[CSR_SPARE_6]     = GAIN_W'($urandom);
               next_settings[CSR_SPARE_7]     = GAIN_W'($urandom);
            end
            default: begin
               next_settings[CSR_GAIN_12V]    = pick_gain(RST_GAIN_12V);
               next_settings[CSR_GAIN_5V]     = pick_gain(RST_GAIN_5V);
               next_settings[CSR_GAIN_3V3]    = pick_gain(RST_GAIN_3V3);
               next_settings[CSR_GAIN_PIN]    = pick_gain(RST_GAIN_PIN);
               next_settings[CSR_SENSOR_GAIN] = pick_gain(RST_SENSOR_GAIN);
               next_settings[CSR_OFFSET_MV]   = ($urandom_range(0, 3) == 0) ?
                  GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 5000));
               next_settings[CSR_SPARE_6]     = GAIN_W'($urandom);
               next_settings[CSR_SPARE_7]     = GAIN_W'($urandom);
            end
         endcase
         sel = (p < 4) ? '1 : CSR_SLOTS'($urandom_range(0, 255));
         load_settings(sel);

         // Idling on and off per phase, none in the closing phase
         if (p == NUM_PHASES - 1) begin
            send_gap_pct   = 0;
            sink_stall_pct = 0;
         end else begin
            send_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 25;
            sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         end

         // Mostly whole blocks; sometimes a partial block spans a setting change
         count = SCANS_PER_BLOCK * $urandom_range(3, 5);
         if ($urandom_range(0, 2) == 0) count += $urandom_range(1, SCANS_PER_BLOCK - 1);

         for (int k = 0; k < count; k++) begin
            // New channel levels at every block boundary
            if (scans_sent % SCANS_PER_BLOCK == 0) begin
               mode = $urandom_range(0, 3);
               foreach (level[c]) level[c] = SAMPLE_W'($urandom_range(0, 4095));
            end
            for (int c = 0; c < NUM_CH; c++) begin
               case (mode)
                  0: v = $urandom_range(0, 4095);
                  1: v = ($urandom_range(0, 1) == 0) ? 0 : 4095;
                  default: begin
                     v = int'(level[c]) + $urandom_range(0, 64) - 32;
                     if (v < 0) v = 0;
                     if (v > 4095) v = 4095;
                  end
               endcase
               case (c)
                  CH_12V: s.sample_rail_12v = SAMPLE_W'(v);
                  CH_5V:  s.sample_rail_5v  = SAMPLE_W'(v);
                  CH_3V3: s.sample_rail_3v3 = SAMPLE_W'(v);
                  default: s.sample_current = SAMPLE_W'(v);
               endcase
            end
            send_scan(s);
         end
         drain();
      end

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Run time limit
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
